// ----- hdl/qn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion normalizer package
// Shared constants and types for the normalizer pipeline and its cells.
// ----------------------------------------------------------------------------
package qn_pkg;

    // Default input component width.
    localparam int IN_WIDTH_DEF = 18;

    // Output format: 16 bits, 14 fraction bits, +1.0 is OUT_ONE.
    localparam int OUT_FRAC = 14;
    localparam int OUT_W    = 16;
    localparam int NB       = OUT_FRAC + 1;
    localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(1 << OUT_FRAC);

    // Threshold register.
    localparam int THR_W = 12;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    // Axis codes for the snapped result.
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2,
        AXIS_W = 2'd3
    } axis_t;

    // Per-item side information carried down the cell chain.
    typedef struct packed {
        logic [3:0] neg;
        logic       was_zero;
        logic       snapped;
        axis_t      axis;
        logic       axis_neg;
    } side_t;

endpackage

// ----- hdl/qn_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion normalizer front end
// Squares the components, sums them, resolves the special cases and seeds
// the residuals for the digit cells. Three pipeline stages.
// ----------------------------------------------------------------------------
module qn_front #(
    parameter int IN_WIDTH = qn_pkg::IN_WIDTH_DEF,
    parameter int SW       = 2 * IN_WIDTH + 1,
    parameter int DW       = 2 * IN_WIDTH + 2 * qn_pkg::OUT_FRAC + 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [qn_pkg::THR_W-1:0]  thr,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [4*IN_WIDTH-1:0]     in_q,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [3:0][DW-1:0]        out_d,
    output logic [3:0][DW-1:0]        out_p,
    output logic [SW-1:0]             out_s,
    output qn_pkg::side_t             out_side
);

    localparam int QW = 2 * IN_WIDTH;

    logic signed [IN_WIDTH-1:0] q_in [4];
    logic [IN_WIDTH-1:0]        mag_in [4];
    logic                       small_in;

    logic                       va_reg;
    logic signed [IN_WIDTH-1:0] qa_reg [4];
    logic [QW-1:0]              sqa_reg [4];
    logic                       smalla_reg;

    logic                       vb_reg;
    logic [QW-1:0]              sqb_reg [4];
    logic [SW-1:0]              sb_reg;
    qn_pkg::side_t              sideb_reg;

    logic                       vc_reg;
    logic [3:0][DW-1:0]         dc_reg;
    logic [3:0][DW-1:0]         pc_reg;
    logic [SW-1:0]              sc_reg;
    qn_pkg::side_t              sidec_reg;

    logic                       rdy_a, rdy_b, rdy_c;
    logic [SW-1:0]              s_sum;
    logic [2*qn_pkg::THR_W-1:0] tsq;
    qn_pkg::side_t              side_b_next;
    logic signed [IN_WIDTH-1:0] x, y, z, w;

    // Stage handshakes: a stage loads when it is empty or drains.
    assign rdy_c    = ~vc_reg | out_ready;
    assign rdy_b    = ~vb_reg | rdy_c;
    assign rdy_a    = ~va_reg | rdy_b;
    assign in_ready = rdy_a;

    // Unpack the components and take magnitudes.
    always_comb begin
        small_in = 1'b1;
        for (int i = 0; i < 4; i++) begin
            q_in[i]   = $signed(in_q[i*IN_WIDTH +: IN_WIDTH]);
            mag_in[i] = q_in[i][IN_WIDTH-1] ? IN_WIDTH'(-q_in[i]) : IN_WIDTH'(q_in[i]);
            if (mag_in[i] > {{(IN_WIDTH-qn_pkg::THR_W){1'b0}}, thr}) begin
                small_in = 1'b0;
            end
        end
    end

    // Stage A: register components, squares and the near-zero flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (rdy_a) begin
            va_reg <= in_valid;
        end
        if (rdy_a && in_valid) begin
            for (int i = 0; i < 4; i++) begin
                qa_reg[i]  <= q_in[i];
                sqa_reg[i] <= QW'(mag_in[i]) * QW'(mag_in[i]);
            end
            smalla_reg <= small_in;
        end
    end

    // Sum of squares, threshold square and axis selection for a snap.
    assign x = qa_reg[0];
    assign y = qa_reg[1];
    assign z = qa_reg[2];
    assign w = qa_reg[3];
    assign tsq = (2*qn_pkg::THR_W)'(thr) * (2*qn_pkg::THR_W)'(thr);

    always_comb begin
        s_sum = SW'(sqa_reg[0]) + SW'(sqa_reg[1]) + SW'(sqa_reg[2]) + SW'(sqa_reg[3]);
        side_b_next.neg      = {w[IN_WIDTH-1], z[IN_WIDTH-1], y[IN_WIDTH-1], x[IN_WIDTH-1]};
        side_b_next.was_zero = smalla_reg;
        side_b_next.snapped  = ~smalla_reg && (s_sum <= SW'(tsq));
        if (x >= y && x >= z && x >= w && !x[IN_WIDTH-1]) begin
            side_b_next.axis = qn_pkg::AXIS_X;
            side_b_next.axis_neg = 1'b0;
        end else if (x <= y && x <= z && x <= w && x <= 0) begin
            side_b_next.axis = qn_pkg::AXIS_X;
            side_b_next.axis_neg = 1'b1;
        end else if (y >= z && y >= w && !y[IN_WIDTH-1]) begin
            side_b_next.axis = qn_pkg::AXIS_Y;
            side_b_next.axis_neg = 1'b0;
        end else if (y <= z && y <= w && y <= 0) begin
            side_b_next.axis = qn_pkg::AXIS_Y;
            side_b_next.axis_neg = 1'b1;
        end else if (z >= w && !z[IN_WIDTH-1]) begin
            side_b_next.axis = qn_pkg::AXIS_Z;
            side_b_next.axis_neg = 1'b0;
        end else if (z <= w && z <= 0) begin
            side_b_next.axis = qn_pkg::AXIS_Z;
            side_b_next.axis_neg = 1'b1;
        end else begin
            side_b_next.axis = qn_pkg::AXIS_W;
            side_b_next.axis_neg = w[IN_WIDTH-1];
        end
    end

    // Stage B: register the sum and the case flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (rdy_b) begin
            vb_reg <= va_reg;
        end
        if (rdy_b && va_reg) begin
            sqb_reg   <= sqa_reg;
            sb_reg    <= s_sum;
            sideb_reg <= side_b_next;
        end
    end

    // Stage C: seed residual R - s and running product -s for digit n = 0.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (rdy_c) begin
            vc_reg <= vb_reg;
        end
        if (rdy_c && vb_reg) begin
            for (int i = 0; i < 4; i++) begin
                dc_reg[i] <= (DW'(sqb_reg[i]) << (2 * qn_pkg::NB)) - DW'(sb_reg);
                pc_reg[i] <= DW'(0) - DW'(sb_reg);
            end
            sc_reg    <= sb_reg;
            sidec_reg <= sideb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_d     = dc_reg;
    assign out_p     = pc_reg;
    assign out_s     = sc_reg;
    assign out_side  = sidec_reg;

endmodule

// ----- hdl/qn_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion normalizer digit cell
// Decides one bit of each scaled component and hands the residuals on.
// ----------------------------------------------------------------------------
module qn_cell #(
    parameter int SW = 37,
    parameter int DW = 72,
    parameter int K  = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [3:0][DW-1:0]          in_d,
    input  logic [3:0][DW-1:0]          in_p,
    input  logic [3:0][qn_pkg::NB-1:0]  in_n,
    input  logic [SW-1:0]               in_s,
    input  qn_pkg::side_t               in_side,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [3:0][DW-1:0]          out_d,
    output logic [3:0][DW-1:0]          out_p,
    output logic [3:0][qn_pkg::NB-1:0]  out_n,
    output logic [SW-1:0]               out_s,
    output qn_pkg::side_t               out_side
);

    logic                       v_reg;
    logic [3:0][DW-1:0]         d_reg, d_next;
    logic [3:0][DW-1:0]         p_reg, p_next;
    logic [3:0][qn_pkg::NB-1:0] n_reg, n_next;
    logic [SW-1:0]              s_reg;
    qn_pkg::side_t              side_reg;
    logic signed [DW-1:0]       trial [4];
    logic [DW-1:0]              sx;

    assign in_ready = ~v_reg | out_ready;
    assign sx = DW'(in_s);

    // Trying n + 2^K adds s * (2^(K+2) * (2n - 1) + 2^(2K+2)) to s * (2n - 1)^2.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            trial[i] = $signed(in_d[i]) - ($signed(in_p[i]) <<< (K + 2))
                     - $signed(sx << (2 * K + 2));
            if (!trial[i][DW-1]) begin
                d_next[i] = DW'(trial[i]);
                p_next[i] = in_p[i] + (sx << (K + 1));
                n_next[i] = in_n[i] | qn_pkg::NB'(1 << K);
            end else begin
                d_next[i] = in_d[i];
                p_next[i] = in_p[i];
                n_next[i] = in_n[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            d_reg    <= d_next;
            p_reg    <= p_next;
            n_reg    <= n_next;
            s_reg    <= in_s;
            side_reg <= in_side;
        end
    end

    assign out_valid = v_reg;
    assign out_d     = d_reg;
    assign out_p     = p_reg;
    assign out_n     = n_reg;
    assign out_s     = s_reg;
    assign out_side  = side_reg;

endmodule

// ----- hdl/quaternion_normalizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion normalizer
// Scales a fixed-point quaternion to unit length, with zero and snap cases.
// ----------------------------------------------------------------------------
// Usage: one quaternion arrives per s_ beat, components x, y, z, w packed
// from the low bits of s_tdata. Each m_ beat carries the normalized
// components as 16-bit values with 14 fraction bits in m_tdata, and the
// was_zero and snapped flags in m_tuser. The cfg channel writes the 12-bit
// near-zero threshold; write it only while the block is idle.
// It holds three front stages, one digit cell per result bit (15 cells), and
// the output register. A new beat is taken every cycle unless the receiver
// stalls and the chain is full; the digit cell chain sets that rate, each
// cell resolving one bit for all four components. Reset empties every stage
// and sets the threshold to 1. When the receiver stalls, the output register
// holds its beat and the stages behind it keep filling until the chain is
// full; only then does s_tready drop.
// ----------------------------------------------------------------------------
module quaternion_normalizer #(
    parameter int IN_WIDTH = qn_pkg::IN_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [qn_pkg::THR_W-1:0]               cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // in_x, in_y, in_z, in_w from the lowest bit up, then zero fill.
    input  logic [((4*IN_WIDTH+7)/8)*8-1:0]        s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // out_x, out_y, out_z, out_w from the lowest bit up.
    output logic [4*qn_pkg::OUT_W-1:0]             m_tdata,
    // was_zero, snapped from the lowest bit up.
    output logic [1:0]                             m_tuser
);

    localparam int SW = 2 * IN_WIDTH + 1;
    localparam int DW = 2 * IN_WIDTH + 2 * qn_pkg::OUT_FRAC + 8;
    localparam int NB = qn_pkg::NB;

    logic [qn_pkg::THR_W-1:0]   thr_reg;

    logic                       lv [NB+1];
    logic                       lr [NB+1];
    logic [3:0][DW-1:0]         ld [NB+1];
    logic [3:0][DW-1:0]         lp [NB+1];
    logic [3:0][NB-1:0]         ln [NB+1];
    logic [SW-1:0]              ls [NB+1];
    qn_pkg::side_t              lside [NB+1];

    logic                       out_load;
    logic [4*qn_pkg::OUT_W-1:0] tdata_next, tdata_reg;
    logic                       tvalid_reg;
    logic [1:0]                 tuser_reg;
    qn_pkg::side_t              fs;

    // Threshold register; writes are always taken.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= qn_pkg::THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    // Front end: squares, sum, special cases and residual seed.
    qn_front #(.IN_WIDTH(IN_WIDTH), .SW(SW), .DW(DW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .thr       (thr_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_q      (s_tdata[4*IN_WIDTH-1:0]),
        .out_valid (lv[0]),
        .out_ready (lr[0]),
        .out_d     (ld[0]),
        .out_p     (lp[0]),
        .out_s     (ls[0]),
        .out_side  (lside[0])
    );
    assign ln[0] = '0;

    // Digit cells, most significant bit first.
    for (genvar j = 0; j < NB; j++) begin : g_cell
        qn_cell #(.SW(SW), .DW(DW), .K(NB - 1 - j)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (lv[j]),
            .in_ready  (lr[j]),
            .in_d      (ld[j]),
            .in_p      (lp[j]),
            .in_n      (ln[j]),
            .in_s      (ls[j]),
            .in_side   (lside[j]),
            .out_valid (lv[j+1]),
            .out_ready (lr[j+1]),
            .out_d     (ld[j+1]),
            .out_p     (lp[j+1]),
            .out_n     (ln[j+1]),
            .out_s     (ls[j+1]),
            .out_side  (lside[j+1])
        );
    end

    // Final component values for the three cases.
    assign fs = lside[NB];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (fs.was_zero) begin
                tdata_next[i*qn_pkg::OUT_W +: qn_pkg::OUT_W] = '0;
            end else if (fs.snapped) begin
                if (fs.axis == qn_pkg::axis_t'(2'(i))) begin
                    tdata_next[i*qn_pkg::OUT_W +: qn_pkg::OUT_W] =
                        fs.axis_neg ? -qn_pkg::OUT_ONE : qn_pkg::OUT_ONE;
                end else begin
                    tdata_next[i*qn_pkg::OUT_W +: qn_pkg::OUT_W] = '0;
                end
            end else begin
                tdata_next[i*qn_pkg::OUT_W +: qn_pkg::OUT_W] = fs.neg[i] ?
                    -qn_pkg::OUT_W'(ln[NB][i]) : qn_pkg::OUT_W'(ln[NB][i]);
            end
        end
    end

    // Output register.
    assign out_load = ~tvalid_reg | m_tready;
    assign lr[NB]   = out_load;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else if (out_load) begin
            tvalid_reg <= lv[NB];
        end
        if (out_load && lv[NB]) begin
            tdata_reg <= tdata_next;
            tuser_reg <= {fs.snapped, fs.was_zero};
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

// ----- hdl/qn_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion normalizer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module qn_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [4*qn_pkg::OUT_W-1:0]   m_tdata,
    input logic [1:0]                   m_tuser
);

    // A stalled beat stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The zero and snap cases never occur together.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("zero and snap flags both set");

    // A zero result carries all-zero components.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("zero result with nonzero data");

    // A snapped result has exactly one nonzero component.
    a_snap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
        $countones({m_tdata[15:0] != 16'd0, m_tdata[31:16] != 16'd0,
                    m_tdata[47:32] != 16'd0, m_tdata[63:48] != 16'd0}) == 1)
        else $error("snapped result is not a single axis");

endmodule

bind quaternion_normalizer qn_checker u_qn_checker (.*);
